FILE: hdl/tps_pkg.sv
`default_nettype none
package tps_pkg;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_RR = 2'd1;
  localparam logic [1:0] POL_SJF = 2'd2;
  localparam logic [1:0] POL_PSJF = 2'd3;
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_QUANTUM = 2'd2;
  localparam logic [15:0] DEFAULT_QUANTUM = 16'd500;

  typedef enum logic [2:0] {
    S_IDLE, S_RETIRE, S_ARRIVE, S_PICK, S_DISPATCH, S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic retire;
    logic arrive_step;
    logic pick_step;
    logic dispatch;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic retire_done;
    logic scan_last;
  } sts_t;
endpackage
`default_nettype wire

FILE: hdl/tps_ctrl.sv
`default_nettype none
module tps_ctrl import tps_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  wire  in_op_i,
  input  wire  out_busy_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !out_busy_i && in_op_i) state_d = S_RETIRE;
      end
      S_RETIRE: begin
        if (sts_i.done || sts_i.retire_done) state_d = S_OUT;
        else state_d = S_ARRIVE;
      end
      S_ARRIVE: begin
        if (sts_i.scan_last) state_d = S_PICK;
      end
      S_PICK: begin
        if (sts_i.scan_last) state_d = S_DISPATCH;
      end
      S_DISPATCH: state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = out_busy_i;
        cmd_o.load = in_valid_i && !out_busy_i && !in_op_i;
        cmd_o.start = in_valid_i && !out_busy_i && in_op_i;
      end
      S_RETIRE: cmd_o.retire = 1'b1;
      S_ARRIVE: cmd_o.arrive_step = 1'b1;
      S_PICK: cmd_o.pick_step = 1'b1;
      S_DISPATCH: cmd_o.dispatch = 1'b1;
      S_OUT: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/tps_datapath.sv
`default_nettype none
module tps_datapath import tps_pkg::*; #(
  parameter int unsigned MaxProcs = 16,
  parameter int unsigned TimeWidth = 20,
  localparam int unsigned SW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1,
  localparam int unsigned CW = $clog2(MaxProcs + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  cmd_t                  cmd_i,
  input  wire  [3:0]            slot_i,
  input  wire  [19:0]           ready_time_i,
  input  wire  [19:0]           exec_time_i,
  input  wire  [1:0]            policy_i,
  input  wire  [4:0]            count_i,
  input  wire  [15:0]           quantum_i,
  output sts_t                  sts_o,
  output logic                  run_v_o,
  output logic [3:0]            run_slot_o,
  output logic                  fin_v_o,
  output logic [3:0]            fin_slot_o,
  output logic                  all_done_o,
  output logic [31:0]           time_o
);
  logic [TimeWidth-1:0] arr_q [MaxProcs];
  logic [TimeWidth-1:0] rem_q [MaxProcs];
  logic [MaxProcs-1:0]  arrived_q;
  logic [SW-1:0]        rq_q [MaxProcs];
  logic [SW-1:0]        head_q, tail_q;
  logic [CW-1:0]        qcnt_q;
  logic [SW-1:0]        cur_q;
  logic                 curv_q;
  logic [4:0]           fcnt_q;
  logic [31:0]          clk_cnt_q;
  logic [15:0]          slice_q;
  logic                 done_q;
  logic [SW-1:0]        idx_q;
  logic                 found_q;
  logic [SW-1:0]        best_q;
  logic                 fin_q;
  logic [SW-1:0]        fin_slot_q;

  // effective count n, clipped to MaxProcs
  logic [8:0] n_w;
  assign n_w = (9'(count_i) > 9'(MaxProcs)) ? 9'(MaxProcs) : 9'(count_i);

  logic last_w;
  assign last_w = (9'(idx_q) + 9'd1 >= n_w) || (32'(idx_q) == MaxProcs - 1);
  assign sts_o.scan_last = last_w;
  assign sts_o.done = done_q;
  assign sts_o.retire_done = curv_q && (rem_q[cur_q] == '0)
                          && (n_w != 0) && (9'(fcnt_q) + 9'd1 >= n_w);

  logic time_hit;
  assign time_hit = (32'(arr_q[idx_q]) == clk_cnt_q);

  logic elig_w;
  assign elig_w = arrived_q[idx_q] && (rem_q[idx_q] != '0);

  logic rr_w;
  assign rr_w = (policy_i == POL_RR);

  logic shortest_w;
  assign shortest_w = (policy_i == POL_SJF) || (policy_i == POL_PSJF);

  // dispatch decision
  logic [SW-1:0] nxt_w;
  logic          have_w;
  logic          push_cur_w;
  logic          pop_w;
  always_comb begin
    nxt_w = cur_q;
    have_w = 1'b0;
    push_cur_w = 1'b0;
    pop_w = 1'b0;
    case (policy_i)
      POL_FIFO, POL_SJF: begin
        if (curv_q) have_w = 1'b1;
        else begin
          have_w = found_q;
          nxt_w = best_q;
        end
      end
      POL_PSJF: begin
        have_w = found_q;
        nxt_w = best_q;
      end
      default: begin
        if (curv_q && slice_q != '0) have_w = 1'b1;
        else begin
          push_cur_w = curv_q && (rem_q[cur_q] != '0);
          if (push_cur_w && qcnt_q < CW'(MaxProcs)) begin
            pop_w = 1'b1;
            have_w = 1'b1;
            nxt_w = (qcnt_q == '0) ? cur_q : rq_q[head_q];
          end else if (qcnt_q != '0) begin
            pop_w = 1'b1;
            have_w = 1'b1;
            nxt_w = rq_q[head_q];
          end
        end
      end
    endcase
  end

  function automatic logic [SW-1:0] inc(input logic [SW-1:0] p);
    inc = (32'(p) + 1 >= MaxProcs) ? '0 : p + SW'(1);
  endfunction

  logic [SW-1:0] run_slot_w;
  logic          run_v_w;
  assign run_v_w = curv_q || have_w;
  assign run_slot_w = have_w ? nxt_w : cur_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && 32'(slot_i) < MaxProcs) begin
      arr_q[SW'(slot_i)] <= TimeWidth'(ready_time_i);
      rem_q[SW'(slot_i)] <= TimeWidth'(exec_time_i);
    end
    if (cmd_i.dispatch && run_v_w && rem_q[run_slot_w] != '0)
      rem_q[run_slot_w] <= rem_q[run_slot_w] - TimeWidth'(1);
    if (cmd_i.arrive_step && rr_w && !arrived_q[idx_q] && time_hit
        && qcnt_q < CW'(MaxProcs))
      rq_q[tail_q] <= idx_q;
    if (cmd_i.dispatch && rr_w && push_cur_w && qcnt_q < CW'(MaxProcs))
      rq_q[tail_q] <= cur_q;
    if (cmd_i.start) begin
      run_v_o <= 1'b0;
      run_slot_o <= '0;
      time_o <= clk_cnt_q;
      all_done_o <= done_q;
    end
    if (cmd_i.dispatch) begin
      run_v_o <= run_v_w;
      run_slot_o <= run_v_w ? 4'(run_slot_w) : 4'd0;
    end
    if (cmd_i.retire && sts_o.retire_done) all_done_o <= 1'b1;
  end
  assign fin_v_o = fin_q;
  assign fin_slot_o = fin_q ? 4'(fin_slot_q) : 4'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrived_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      qcnt_q <= '0;
      cur_q <= '0;
      curv_q <= 1'b0;
      fcnt_q <= '0;
      clk_cnt_q <= '0;
      slice_q <= '0;
      done_q <= 1'b0;
      idx_q <= '0;
      found_q <= 1'b0;
      best_q <= '0;
      fin_q <= 1'b0;
      fin_slot_q <= '0;
    end else begin
      if (cmd_i.load && 32'(slot_i) < MaxProcs) arrived_q[SW'(slot_i)] <= 1'b0;
      if (cmd_i.start) begin
        idx_q <= '0;
        found_q <= 1'b0;
        best_q <= '0;
        fin_q <= 1'b0;
      end
      if (cmd_i.retire && !done_q && curv_q && rem_q[cur_q] == '0) begin
        fin_q <= 1'b1;
        fin_slot_q <= cur_q;
        curv_q <= 1'b0;
        if (fcnt_q < 5'd31) fcnt_q <= fcnt_q + 5'd1;
        if (sts_o.retire_done) done_q <= 1'b1;
      end
      if (cmd_i.arrive_step) begin
        if (n_w != 0 && !arrived_q[idx_q] && time_hit) begin
          arrived_q[idx_q] <= 1'b1;
          if (rr_w && qcnt_q < CW'(MaxProcs)) begin
            tail_q <= inc(tail_q);
            qcnt_q <= qcnt_q + CW'(1);
          end
        end
        idx_q <= last_w ? '0 : idx_q + SW'(1);
      end
      if (cmd_i.pick_step) begin
        if (n_w != 0 && elig_w && (!found_q ||
            (shortest_w && rem_q[idx_q] < rem_q[best_q]))) begin
          best_q <= idx_q;
          found_q <= 1'b1;
        end
        idx_q <= last_w ? '0 : idx_q + SW'(1);
      end
      if (cmd_i.dispatch) begin
        if (rr_w && !(curv_q && slice_q != '0)) begin
          if (push_cur_w && qcnt_q < CW'(MaxProcs)) begin
            tail_q <= inc(tail_q);
            head_q <= inc(head_q);
          end else if (qcnt_q != '0) begin
            head_q <= inc(head_q);
            qcnt_q <= qcnt_q - CW'(1);
          end
        end
        if (have_w) begin
          cur_q <= nxt_w;
          curv_q <= 1'b1;
        end
        if (rr_w && pop_w) begin
          slice_q <= (16'd1 >= quantum_i) ? 16'd0 : 16'd1;
        end else begin
          slice_q <= (slice_q + 16'd1 >= quantum_i) ? 16'd0 : slice_q + 16'd1;
        end
        clk_cnt_q <= clk_cnt_q + 32'd1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/tick_process_scheduler.sv
// channel | valid      | stall      | payload
// in      | in_valid_i | in_stall_o | operation_i slot_i ready_time_i exec_time_i
// out     | out_valid_o| out_stall_i| running_* finished_* all_done_o time_now_o
// A load request is taken while idle. A tick request, n the clipped process
// count, fills the output register after these steps: retire, arrival sweep
// and pick sweep over n slots each, dispatch, output; a completing or frozen
// tick skips the sweeps and dispatch and goes from retire to output.
// Reset clears all control state; the tables need loads before use.
// A new request waits while a result sits unaccepted in the output register.
`default_nettype none
module tick_process_scheduler import tps_pkg::*; #(
  parameter int unsigned MaxProcs = 16,
  parameter int unsigned TimeWidth = 20
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         operation_i,
  input  wire  [3:0]  slot_i,
  input  wire  [19:0] ready_time_i,
  input  wire  [19:0] exec_time_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        running_valid_o,
  output logic [3:0]  running_slot_o,
  output logic        finished_valid_o,
  output logic [3:0]  finished_slot_o,
  output logic        all_done_o,
  output logic [31:0] time_now_o
);
  logic [1:0]  policy_q;
  logic [4:0]  count_q;
  logic [15:0] quantum_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIFO;
      count_q <= 5'd1;
      quantum_q <= DEFAULT_QUANTUM;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POLICY: policy_q <= cfg_data_i[1:0];
        REG_COUNT: count_q <= cfg_data_i[4:0];
        REG_QUANTUM: quantum_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd.finish) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  tps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_op_i(operation_i),
    .out_busy_i(out_valid_o), .sts_i(sts), .in_stall_o, .cmd_o(cmd)
  );

  tps_datapath #(.MaxProcs(MaxProcs), .TimeWidth(TimeWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .slot_i, .ready_time_i, .exec_time_i,
    .policy_i(policy_q), .count_i(count_q), .quantum_i(quantum_q),
    .sts_o(sts), .run_v_o(running_valid_o), .run_slot_o(running_slot_o),
    .fin_v_o(finished_valid_o), .fin_slot_o(finished_slot_o),
    .all_done_o, .time_o(time_now_o)
  );
endmodule
`default_nettype wire

FILE: hdl/tps_checker.sv
`default_nettype none
module tps_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire        running_valid_o,
  input wire        finished_valid_o,
  input wire        all_done_o,
  input wire [31:0] time_now_o
);
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request taken over pending result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(time_now_o))
    else $error("stalled result changed");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_done_o |-> !running_valid_o)
    else $error("run reported after completion");
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && running_valid_o && finished_valid_o |-> !all_done_o)
    else $error("inconsistent result");
endmodule
bind tick_process_scheduler tps_checker u_tps_checker (.*);
`default_nettype wire
